[rtl/led_effect_brightness_generator_defines.svh]
// ---------------------------------------------------------------------------
// LED effect generator assertion macros
// Shared property wrappers for the checker that watches the top level.
// ---------------------------------------------------------------------------
`ifndef LED_EFFECT_BRIGHTNESS_GENERATOR_DEFINES_SVH
`define LED_EFFECT_BRIGHTNESS_GENERATOR_DEFINES_SVH

// Concurrent assertion on a given clock with an active-low reset disable.
`define LEBG_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the default clock and reset names of this project.
`define LEBG_ASSERT(lbl, prop, msg) `LEBG_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/lebg_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED effect generator package
// Widths, codes, constants and shared types of the brightness generator.
// ---------------------------------------------------------------------------
package lebg_pkg;

  localparam int TIME_BITS  = 32;
  localparam int PHASE_W    = 26;
  localparam int LEVEL_W    = 8;
  localparam int PROD_W     = PHASE_W + LEVEL_W;
  localparam int DIV_W      = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int MIN_STEP_US = 1000;
  localparam int US_PER_MS   = 1000;
  localparam int FULL_LEVEL  = 255;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [PHASE_W-1:0]    phase_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [DIV_W-1:0]      div_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes.
  localparam cfg_idx_t REG_MODE      = 3'd0;
  localparam cfg_idx_t REG_PERIOD    = 3'd1;
  localparam cfg_idx_t REG_MIN_LEVEL = 3'd2;
  localparam cfg_idx_t REG_MAX_LEVEL = 3'd3;

  // Effect modes; codes six and seven leave the level alone.
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_ON       = 3'd1;
  localparam logic [2:0] MODE_BLINK    = 3'd2;
  localparam logic [2:0] MODE_BREATHE  = 3'd3;
  localparam logic [2:0] MODE_FADE_IN  = 3'd4;
  localparam logic [2:0] MODE_FADE_OUT = 3'd5;

  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] cycle_ms;
    level_t      min_level;
    level_t      max_level;
  } cfg_t;

  typedef enum logic [0:0] {
    ITEM_HOLD = 1'b0,
    ITEM_STEP = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    time_t      dt;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } fifo_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fifo_rd_t;

endpackage

[rtl/lebg_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Time stamp channel
// Valid/ready channel that carries one microsecond time stamp per request.
// ---------------------------------------------------------------------------
interface lebg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_us;

  modport source (output valid, output now_us, input ready);
  modport sink (input valid, input now_us, output ready);
endinterface

[rtl/lebg_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Brightness result channel
// Valid/ready channel that carries the brightness and its change flag.
// ---------------------------------------------------------------------------
interface lebg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] brightness;
  logic       changed;

  modport source (output valid, output brightness, output changed, input ready);
  modport sink (input valid, input brightness, input changed, output ready);
endinterface

[rtl/lebg_cfg_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ---------------------------------------------------------------------------
interface lebg_cfg_if import lebg_pkg::*; ;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lebg_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Classified request queue
// Short register queue between the front and back parts of the generator.
// ---------------------------------------------------------------------------
module lebg_fifo import lebg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fifo_wr_t wr_i,
  input  logic     pop_i,
  output fifo_rd_t rd_o,
  output logic     full_o
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o   = (count_q == CNT_W'(FIFO_DEPTH));
  assign do_push  = wr_i.push && !full_o;
  assign do_pop   = pop_i && (count_q != '0);
  assign rd_o.valid = (count_q != '0);
  assign rd_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

endmodule

[rtl/lebg_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Time stamp front end
// Accepts time stamps, tracks the last latched time and classifies each
// request as a hold or as a step that advances the effect phase.
// ---------------------------------------------------------------------------
module lebg_front import lebg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [31:0] in_now_us_i,
  output logic        in_ready_o,
  input  cfg_t        cfg_i,
  input  logic        cfg_we_i,
  input  logic        fifo_full_i,
  output fifo_wr_t    fifo_wr_o
);

  time_t last_q, last_d;
  logic  latched_q, latched_d;
  time_t now;
  time_t dt;
  logic  accept;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign now        = time_t'(in_now_us_i);
  assign dt         = now - last_q;

  always_comb begin
    last_d              = last_q;
    latched_d           = latched_q;
    fifo_wr_o.push      = accept;
    fifo_wr_o.item.kind = ITEM_HOLD;
    fifo_wr_o.item.dt   = dt;
    if (accept) begin
      if (!latched_q || (now < last_q)) begin
        // Nothing to measure against: only take the time.
        latched_d = 1'b1;
        last_d    = now;
      end else if (dt >= time_t'(MIN_STEP_US)) begin
        last_d = now;
        if (cfg_i.cycle_ms != '0) begin
          fifo_wr_o.item.kind = ITEM_STEP;
        end
      end
    end
    if (cfg_we_i) begin
      latched_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      latched_q <= 1'b0;
    end else begin
      last_q    <= last_d;
      latched_q <= latched_d;
    end
  end

endmodule

[rtl/lebg_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// phase wrap and the ramp quotients with a variable divisor.
// ---------------------------------------------------------------------------
module lebg_div import lebg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  div_t   dividend_i,
  input  phase_t divisor_i,
  output div_t   quotient_o,
  output phase_t remainder_o,
  output logic   done_o
);

  localparam int CNT_W = $clog2(DIV_W);

  div_t             quo_q, quo_d;
  phase_t           rem_q, rem_d;
  phase_t           den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [PHASE_W:0] trial;
  logic [PHASE_W:0] diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CNT_W'(DIV_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[PHASE_W-1:0] : trial[PHASE_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

[rtl/lebg_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Effect back end
// Pops classified requests, advances the phase, evaluates the effect with
// the shared divider and holds the result in an output register.
// ---------------------------------------------------------------------------
module lebg_back import lebg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  cfg_t     cfg_next_i,
  input  logic     cfg_we_i,
  input  fifo_rd_t fifo_rd_i,
  output logic     fifo_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output level_t   brightness_o,
  output logic     changed_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_PHASE = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_MULD  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_SCALE = 3'd7;

  logic [2:0]  state_q, state_d;
  phase_t      phase_q, phase_d;
  phase_t      rem_q, rem_d;
  level_t      level_q, level_d;
  level_t      nb_q, nb_d;
  level_t      a_q, a_d;
  phase_t      b_q, b_d;
  phase_t      den_q, den_d;
  level_t      base_q, base_d;
  logic        neg_q, neg_d;
  logic        first_q, first_d;
  logic        out_valid_q, out_valid_d;
  level_t      out_b_q, out_b_d;
  logic        out_chg_q, out_chg_d;

  phase_t      cycle_us;
  phase_t      half;
  logic        dneg;
  level_t      absd;
  logic [PHASE_W:0] sum;
  logic [PROD_W-1:0] prod;
  level_t      q8;
  logic [2*LEVEL_W-1:0] span_prod;
  logic [2*LEVEL_W:0]   span_acc;
  level_t      span_div;

  logic        div_start;
  div_t        div_dividend;
  phase_t      div_divisor;
  div_t        div_quo;
  phase_t      div_rem;
  logic        div_done;

  lebg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  assign cycle_us  = phase_t'(cfg_i.cycle_ms * US_PER_MS);
  assign half      = cycle_us >> 1;
  assign dneg      = (cfg_i.min_level > cfg_i.max_level);
  assign absd      = dneg ? (cfg_i.min_level - cfg_i.max_level)
                          : (cfg_i.max_level - cfg_i.min_level);
  assign sum       = {1'b0, phase_q} + {1'b0, rem_q};
  assign prod      = PROD_W'(a_q) * PROD_W'(b_q);
  assign q8        = div_quo[LEVEL_W-1:0];

  // A product of two bytes divided by 255 is (x + (x >> 8) + 1) >> 8.
  assign span_prod = prod[2*LEVEL_W-1:0];
  assign span_acc  = {1'b0, span_prod}
                   + {{(LEVEL_W+1){1'b0}}, span_prod[2*LEVEL_W-1:LEVEL_W]}
                   + {{(2*LEVEL_W){1'b0}}, 1'b1};
  assign span_div  = span_acc[2*LEVEL_W-1:LEVEL_W];

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    rem_d        = rem_q;
    level_d      = level_q;
    nb_d         = nb_q;
    a_d          = a_q;
    b_d          = b_q;
    den_d        = den_q;
    base_d       = base_q;
    neg_d        = neg_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q;
    out_b_d      = out_b_q;
    out_chg_d    = out_chg_q;
    fifo_pop_o   = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_t'(prod);
    div_divisor  = den_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (fifo_rd_i.valid) begin
          fifo_pop_o = 1'b1;
          if (fifo_rd_i.item.kind == ITEM_STEP) begin
            div_start    = 1'b1;
            div_dividend = div_t'(fifo_rd_i.item.dt);
            div_divisor  = cycle_us;
            state_d      = S_MOD;
          end else begin
            nb_d    = level_q;
            state_d = S_DONE;
          end
        end
      end
      S_MOD: begin
        if (div_done) begin
          rem_d   = div_rem;
          state_d = S_PHASE;
        end
      end
      S_PHASE: begin
        // Both terms are below the period, so one subtraction wraps the sum.
        if (sum >= {1'b0, cycle_us}) begin
          phase_d = phase_t'(sum - {1'b0, cycle_us});
        end else begin
          phase_d = sum[PHASE_W-1:0];
        end
        state_d = S_EVAL;
      end
      S_EVAL: begin
        case (cfg_i.mode)
          MODE_BLINK: begin
            nb_d    = (phase_q < half) ? cfg_i.max_level : cfg_i.min_level;
            state_d = S_DONE;
          end
          MODE_BREATHE: begin
            // First pass scales the half-period position to 0..255.
            a_d     = level_t'(FULL_LEVEL);
            den_d   = half;
            first_d = 1'b1;
            if (phase_q < half) begin
              b_d    = phase_q;
              base_d = cfg_i.min_level;
              neg_d  = 1'b0;
            end else begin
              b_d    = phase_q - half;
              base_d = cfg_i.max_level;
              neg_d  = 1'b1;
            end
            state_d = S_MULD;
          end
          MODE_FADE_IN: begin
            a_d     = absd;
            b_d     = phase_q;
            den_d   = cycle_us;
            first_d = 1'b0;
            base_d  = cfg_i.min_level;
            neg_d   = 1'b0;
            state_d = S_MULD;
          end
          MODE_FADE_OUT: begin
            a_d     = absd;
            b_d     = phase_q;
            den_d   = cycle_us;
            first_d = 1'b0;
            base_d  = cfg_i.max_level;
            neg_d   = 1'b1;
            state_d = S_MULD;
          end
          default: begin
            nb_d    = level_q;
            state_d = S_DONE;
          end
        endcase
      end
      S_MULD: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (first_q) begin
            a_d     = absd;
            b_d     = phase_t'(q8);
            first_d = 1'b0;
            state_d = S_SCALE;
          end else begin
            // The quotient is the magnitude of the signed term.
            nb_d    = (neg_q ^ dneg) ? (base_q - q8) : (base_q + q8);
            state_d = S_DONE;
          end
        end
      end
      S_SCALE: begin
        // Breathe span: the magnitude times the position, over 255.
        nb_d    = (neg_q ^ dneg) ? (base_q - span_div) : (base_q + span_div);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_b_d     = nb_q;
          out_chg_d   = (nb_q != level_q);
          level_d     = nb_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      phase_d = '0;
      if (cfg_next_i.mode == MODE_OFF) begin
        level_d = '0;
      end else if (cfg_next_i.mode == MODE_ON) begin
        level_d = cfg_next_i.max_level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    nb_q      <= nb_d;
    a_q       <= a_d;
    b_q       <= b_d;
    den_q     <= den_d;
    base_q    <= base_d;
    neg_q     <= neg_d;
    first_q   <= first_d;
    out_b_q   <= out_b_d;
    out_chg_q <= out_chg_d;
  end

  assign out_valid_o  = out_valid_q;
  assign brightness_o = out_b_q;
  assign changed_o    = out_chg_q;

endmodule

[rtl/led_effect_brightness_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED effect brightness generator
// Turns microsecond time stamps into an 8-bit brightness for off, on,
// blink, breathe, fade-in and fade-out effects.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Payload                    | Handshake
//  --------+-----------+----------------------------+------------------
//  in_i    | sink      | now_us[31:0]               | valid / ready
//  out_o   | source    | brightness[7:0], changed   | valid / ready
//  cfg_i   | sink      | index[2:0], data[15:0]     | valid / ready (=1)
//
//  A hold request (first stamp, stamp going backwards, step under 1 ms or a
//  zero period) is done without the divider. A step request runs the
//  restoring divider once for the phase wrap and, in the ramp modes, once
//  more for the ramp quotient. A two-entry queue lets the front take new
//  stamps while the back end works or while a result waits in the output
//  register.
//  Reset is asynchronous and active low; no clearing pass is needed.
//
module led_effect_brightness_generator import lebg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lebg_in_if.sink    in_i,
  lebg_out_if.source out_o,
  lebg_cfg_if.sink   cfg_i
);

  // Configuration registers. The back end and the front both see the
  // current values; the back end also sees the value being written so a
  // write can set the level for the on and off modes in the same cycle.
  cfg_t     cfg_q, cfg_d;
  logic     cfg_we;
  logic     cfg_hit;

  fifo_wr_t fifo_wr;
  fifo_rd_t fifo_rd;
  logic     fifo_full;
  logic     fifo_pop;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit     = cfg_i.index inside {[REG_MODE:REG_MAX_LEVEL]};
  assign cfg_we      = cfg_i.valid && cfg_i.ready && cfg_hit;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_MODE:      cfg_d.mode      = cfg_i.data[2:0];
        REG_PERIOD:    cfg_d.cycle_ms  = cfg_i.data;
        REG_MIN_LEVEL: cfg_d.min_level = cfg_i.data[LEVEL_W-1:0];
        REG_MAX_LEVEL: cfg_d.max_level = cfg_i.data[LEVEL_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_OFF;
      cfg_q.cycle_ms  <= PERIOD_RESET;
      cfg_q.min_level <= '0;
      cfg_q.max_level <= level_t'(FULL_LEVEL);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front part: time bookkeeping and classification of each stamp.
  lebg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_now_us_i (in_i.now_us),
    .in_ready_o  (in_i.ready),
    .cfg_i       (cfg_q),
    .cfg_we_i    (cfg_we),
    .fifo_full_i (fifo_full),
    .fifo_wr_o   (fifo_wr)
  );

  lebg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fifo_wr),
    .pop_i  (fifo_pop),
    .rd_o   (fifo_rd),
    .full_o (fifo_full)
  );

  // Back part: phase, effect evaluation and the output register.
  lebg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cfg_next_i   (cfg_d),
    .cfg_we_i     (cfg_we),
    .fifo_rd_i    (fifo_rd),
    .fifo_pop_o   (fifo_pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .brightness_o (out_o.brightness),
    .changed_o    (out_o.changed)
  );

endmodule

[rtl/lebg_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED effect generator port checker
// Watches the top-level ports for stray results, change-flag and flow-control slips.
// ---------------------------------------------------------------------------
`include "led_effect_brightness_generator_defines.svh"

module lebg_checker import lebg_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] brightness_i,
  input logic       changed_i,
  input logic       cfg_valid_i,
  input logic       cfg_ready_i
);

  // Queue entries, the request in the back end and the output register.
  localparam int MAX_PENDING = FIFO_DEPTH + 2;
  localparam int PEND_W      = $clog2(MAX_PENDING + 1);

  logic [PEND_W-1:0] pending_q;
  logic [7:0]        prev_b_q;
  logic              have_prev_q;
  logic              cfg_since_q;
  logic              in_acc;
  logic              out_acc;
  logic              cfg_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      have_prev_q <= 1'b0;
      cfg_since_q <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        pending_q <= pending_q + 1'b1;
      end else if (out_acc && !in_acc) begin
        pending_q <= pending_q - 1'b1;
      end
      if (out_acc) begin
        have_prev_q <= 1'b1;
        cfg_since_q <= 1'b0;
      end
      if (cfg_acc) begin
        cfg_since_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      prev_b_q <= brightness_i;
    end
  end

  `LEBG_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(brightness_i) && $stable(changed_i), "stalled result changed")
  `LEBG_ASSERT(a_no_extra, out_valid_i |-> pending_q != '0, "result without an accepted request")
  `LEBG_ASSERT(a_full_stall, pending_q == PEND_W'(MAX_PENDING) |-> !in_ready_i, "request taken with no room left")
  `LEBG_ASSERT(a_change_flag, out_acc && changed_i && have_prev_q && !cfg_since_q |-> brightness_i != prev_b_q, "change flag set with the same brightness")

endmodule

bind led_effect_brightness_generator lebg_checker u_lebg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .brightness_i (out_o.brightness),
  .changed_i    (out_o.changed),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);

[verif/lebg_brightness_check.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Brightness prediction and compare
// Watches the time stamp, result and register channels of the LED effect
// generator, predicts each brightness and change flag, and counts mismatches.
// ---------------------------------------------------------------------------
module lebg_brightness_check import lebg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lebg_in_if   stamp_mon,
  lebg_out_if  level_mon,
  lebg_cfg_if  reg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    level_t level;
    logic   changed;
  } shade_t;

  // Registers as the block should hold them.
  logic [2:0]      mode_r;
  logic [15:0]     period_r;
  level_t          min_r;
  level_t          max_r;

  // Effect state.
  time_t           last_stamp;
  longint unsigned phase;
  level_t          level_r;
  bit              latched;

  shade_t          shade_q[$];
  int              fails = 0;

  assign fail_count_o = fails;

  // base plus or minus (max - min) * num / den, truncated toward zero, 8-bit wrap.
  function automatic level_t ramp_level(level_t base, bit down, longint unsigned num,
                                        longint unsigned den);
    longint span;
    longint term;
    span = longint'(max_r) - longint'(min_r);
    term = (span * longint'(num)) / longint'(den);
    return down ? level_t'(longint'(base) - term) : level_t'(longint'(base) + term);
  endfunction

  function automatic void apply_register(cfg_idx_t idx, cfg_data_t value);
    case (idx)
      REG_MODE:      mode_r = value[2:0];
      REG_PERIOD:    period_r = value;
      REG_MIN_LEVEL: min_r = value[7:0];
      REG_MAX_LEVEL: max_r = value[7:0];
      default:       return;
    endcase
    phase   = 0;
    latched = 1'b0;
    if (mode_r == MODE_OFF) level_r = '0;
    else if (mode_r == MODE_ON) level_r = max_r;
  endfunction

  function automatic shade_t advance_effect(time_t stamp);
    longint unsigned cycle_us;
    longint unsigned dt;
    longint unsigned t;
    longint unsigned half;
    level_t          next;
    shade_t          res;
    cycle_us    = 64'(period_r) * US_PER_MS;
    res.changed = 1'b0;
    if (!latched || stamp < last_stamp) begin
      latched    = 1'b1;
      last_stamp = stamp;
    end else begin
      dt = 64'(stamp) - 64'(last_stamp);
      if (dt >= MIN_STEP_US) begin
        last_stamp = stamp;
        if (cycle_us != 0) begin
          phase = (phase + dt % cycle_us) % cycle_us;
          t     = phase;
          half  = cycle_us / 2;
          next  = level_r;
          case (mode_r)
            MODE_BLINK:    next = (t < half) ? max_r : min_r;
            MODE_BREATHE: begin
              if (t < half) next = ramp_level(min_r, 1'b0, (t * FULL_LEVEL) / half, FULL_LEVEL);
              else next = ramp_level(max_r, 1'b1, ((t - half) * FULL_LEVEL) / half, FULL_LEVEL);
            end
            MODE_FADE_IN:  next = ramp_level(min_r, 1'b0, t, cycle_us);
            MODE_FADE_OUT: next = ramp_level(max_r, 1'b1, t, cycle_us);
            default:       ;
          endcase
          if (next != level_r) begin
            level_r     = next;
            res.changed = 1'b1;
          end
        end
      end
    end
    res.level = level_r;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shade_t want;
    if (!rst_ni) begin
      mode_r     = MODE_OFF;
      period_r   = PERIOD_RESET;
      min_r      = '0;
      max_r      = '1;
      last_stamp = '0;
      phase      = 0;
      level_r    = '0;
      latched    = 1'b0;
      shade_q.delete();
      pending_o <= 0;
    end else begin
      // Results leave before this edge's request is counted.
      if (level_mon.valid && level_mon.ready) begin
        if (shade_q.size() == 0) begin
          $display("%0t: result with nothing expected, brightness %0d changed %0d",
                   $time, level_mon.brightness, level_mon.changed);
          fails++;
        end else begin
          want = shade_q.pop_front();
          if (level_mon.brightness !== want.level) begin
            $display("%0t: brightness expected %0d actual %0d",
                     $time, want.level, level_mon.brightness);
            fails++;
          end
          if (level_mon.changed !== want.changed) begin
            $display("%0t: changed expected %0d actual %0d",
                     $time, want.changed, level_mon.changed);
            fails++;
          end
        end
      end
      if (reg_mon.valid && reg_mon.ready) apply_register(reg_mon.index, reg_mon.data);
      if (stamp_mon.valid && stamp_mon.ready) shade_q.push_back(advance_effect(stamp_mon.now_us));
      pending_o <= shade_q.size();
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED effect brightness generator testbench
// Drives time stamps and register writes into the generator under random
// sender gaps and receiver stalls; a separate checker predicts every result.
// ---------------------------------------------------------------------------
module tb;
  import lebg_pkg::*;

  // Mode codes with no effect and register indexes that hit no register.
  localparam logic [2:0] MODE_SPARE_LO    = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI    = 3'd7;
  localparam cfg_idx_t   REG_UNUSED_FIRST = 3'd4;
  localparam cfg_idx_t   REG_UNUSED_LAST  = 3'd7;

  // Roughly how many random requests to send, and how long to wait for
  // stray results once everything has come back.
  localparam int RANDOM_REQUESTS = 850;
  localparam int DRAIN_CYCLES    = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lebg_in_if  stamp_ch ();
  lebg_out_if level_ch ();
  lebg_cfg_if reg_ch ();

  int          fail_count;
  int          pending;

  // Traffic shaping: the sender goes in bursts, the receiver stalls on its own.
  bit          gaps_on    = 1'b0;
  bit          stalls_on  = 1'b0;
  int          burst_left = 0;
  int          stall_left = 0;

  // Period last written, used only to size the time steps sensibly.
  logic [15:0] cur_period = PERIOD_RESET;
  time_t       stamp;

  led_effect_brightness_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stamp_ch),
    .out_o  (level_ch),
    .cfg_i  (reg_ch)
  );

  lebg_brightness_check i_brightness_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stamp_mon    (stamp_ch),
    .level_mon    (level_ch),
    .reg_mon      (reg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: while stalls are enabled, it now and then drops ready for a
  // random stretch counted down in stall_left.
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      level_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      level_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      level_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
    end
  end

  // Sends one time stamp and returns at the edge where it is taken. Valid
  // stays high afterwards so that back-to-back requests need no gap; a burst
  // that runs out inserts a random gap first when gaps are enabled.
  task automatic send_stamp(input time_t value);
    if (burst_left == 0) begin
      if (gaps_on) begin
        stamp_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    stamp_ch.valid  <= 1'b1;
    stamp_ch.now_us <= value;
    do @(posedge clk_i); while (!stamp_ch.ready);
  endtask

  // Closes a run of requests; called in the step of the last handshake.
  task automatic stamps_done();
    stamp_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted result has been taken. The first edge lets
  // the checker count the request accepted in the current step.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= value;
    do @(posedge clk_i); while (!reg_ch.ready);
    if (idx == REG_PERIOD) cur_period = value;
  endtask

  task automatic regs_done();
    reg_ch.valid <= 1'b0;
  endtask

  // Full register set once the block is idle. Mode goes last so that a
  // switch to mode on picks up the new maximum.
  task automatic program_all(input logic [2:0] mode, input logic [15:0] cycle_ms,
                             input level_t lo, input level_t hi);
    wait_drained();
    write_reg(REG_PERIOD, cycle_ms);
    write_reg(REG_MIN_LEVEL, cfg_data_t'(lo));
    write_reg(REG_MAX_LEVEL, cfg_data_t'(hi));
    write_reg(REG_MODE, cfg_data_t'(mode));
    regs_done();
  endtask

  function automatic level_t pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return level_t'($urandom);
    endcase
  endfunction

  // One random phase: a few register writes (sometimes none, so state carries
  // over), then a run of mostly well-formed steps with some short steps,
  // backward jumps and very long jumps mixed in.
  task automatic random_phase(output int sent);
    int          writes;
    int          count;
    int unsigned span_us;
    cfg_data_t   value;
    logic [2:0]  mode;
    wait_drained();
    gaps_on   = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
    writes    = $urandom_range(0, 4);
    for (int w = 0; w < writes; w++) begin
      value = cfg_data_t'($urandom);
      case ($urandom_range(0, 8))
        0, 1: begin
          if ($urandom_range(0, 3) == 0) mode = 3'($urandom_range(0, 7));
          else mode = 3'($urandom_range(MODE_BLINK, MODE_FADE_OUT));
          value[2:0] = mode;
          write_reg(REG_MODE, value);
        end
        2, 3: begin
          case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = '1;
            2:       ;
            default: value = cfg_data_t'($urandom_range(1, 20));
          endcase
          write_reg(REG_PERIOD, value);
        end
        4, 5: begin
          value[7:0] = pick_level();
          write_reg(REG_MIN_LEVEL, value);
        end
        6, 7: begin
          value[7:0] = pick_level();
          write_reg(REG_MAX_LEVEL, value);
        end
        default: write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), value);
      endcase
    end
    if (writes != 0) begin
      regs_done();
      case ($urandom_range(0, 5))
        0:       stamp = '1 - time_t'($urandom_range(0, 200000));
        1:       stamp = '0;
        default: stamp = time_t'($urandom);
      endcase
    end
    span_us = (cur_period == 0) ? 20000 : 32'(cur_period) * US_PER_MS;
    count   = $urandom_range(8, 40);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0:       stamp = stamp - time_t'($urandom_range(1, 5000));
        1:       stamp = stamp + time_t'($urandom_range(0, MIN_STEP_US - 1));
        2:       stamp = stamp + time_t'($urandom);
        3:       stamp = stamp + time_t'(MIN_STEP_US);
        default: stamp = stamp + time_t'($urandom_range(MIN_STEP_US, span_us / 4 + MIN_STEP_US));
      endcase
      send_stamp(stamp);
    end
    stamps_done();
    sent = count;
  endtask

  initial begin
    int sent;
    int total;
    stamp_ch.valid  <= 1'b0;
    stamp_ch.now_us <= '0;
    reg_ch.valid    <= 1'b0;
    reg_ch.index    <= REG_MODE;
    reg_ch.data     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, mode off: the first stamp only latches the time, a step
    // under one millisecond is ignored, and a full step changes nothing.
    send_stamp(32'd0);
    send_stamp(32'd500);
    send_stamp(32'd1500);
    stamps_done();

    // Fade in over 10 ms, a backward jump, and a long jump up to the top of
    // the time range followed by a wrap back to a small stamp.
    program_all(MODE_FADE_IN, 16'd10, 8'd0, 8'd255);
    send_stamp(32'd100);
    send_stamp(32'd3600);
    send_stamp(32'd3000);
    send_stamp(32'd8000);
    send_stamp(32'hFFFF_F000);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'd5);
    stamps_done();

    // Breathe with the minimum above the maximum, so the ramp runs negative.
    program_all(MODE_BREATHE, 16'd7, 8'd200, 8'd20);
    send_stamp(32'd0);
    send_stamp(32'd2500);
    send_stamp(32'd4000);
    send_stamp(32'd9000);
    stamps_done();

    // Zero period: stamps are latched and nothing else moves.
    program_all(MODE_FADE_OUT, 16'd0, 8'd10, 8'd90);
    send_stamp(32'd0);
    send_stamp(32'd5000);
    stamps_done();

    // Longest period with both mode codes that have no effect, plus a write
    // to an index that holds no register.
    program_all(MODE_SPARE_LO, 16'hFFFF, 8'd0, 8'd255);
    send_stamp(32'd0);
    send_stamp(32'd2000);
    stamps_done();
    wait_drained();
    write_reg(REG_MODE, cfg_data_t'(MODE_SPARE_HI));
    write_reg(REG_UNUSED_FIRST, '1);
    regs_done();
    send_stamp(32'd0);
    send_stamp(32'd1500);
    stamps_done();

    // Blink across both halves of a 2 ms period.
    program_all(MODE_BLINK, 16'd2, 8'd33, 8'd222);
    send_stamp(32'd0);
    send_stamp(32'd1000);
    send_stamp(32'd2000);
    send_stamp(32'd3000);
    stamps_done();

    // Mode on takes the maximum at the write and ignores stamps.
    program_all(MODE_ON, 16'd1, 8'd0, 8'd77);
    send_stamp(32'd0);
    send_stamp(32'd1000);
    stamps_done();
    wait_drained();
    write_reg(REG_UNUSED_LAST, '0);
    write_reg(REG_MODE, cfg_data_t'(MODE_OFF));
    regs_done();

    // Random phases until enough requests have gone in.
    total = 0;
    while (total < RANDOM_REQUESTS) begin
      random_phase(sent);
      total += sent;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
